/* rtl/cbf_pkg.sv */
// types, constants and helpers shared by the bezier flattener
package cbf_pkg;

   localparam int COORD_BITS = 24;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int ERR_BITS   = 32;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int MUL_BITS  = 64;
   localparam int PROD_BITS = 2 * MUL_BITS;

   localparam logic [CSR_IDX_BITS-1:0] CSR_CLIP_LEFT   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CLIP_TOP    = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CLIP_RIGHT  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CLIP_BOTTOM = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_ERR_SQ  = 3'd4;

   localparam logic [1:0] SIDE_LEFT  = 2'd1;
   localparam logic [1:0] SIDE_RIGHT = 2'd2;
   localparam logic [1:0] SIDE_DONE  = 2'd3;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [3:0][COORD_BITS-1:0] coord4_type;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type ctrl_a_x;
      coord_type ctrl_a_y;
      coord_type ctrl_b_x;
      coord_type ctrl_b_y;
      coord_type end_x;
      coord_type end_y;
   } req_type;

   typedef struct packed {
      coord_type out_x;
      coord_type out_y;
      logic      last;
   } rsp_type;

   typedef struct packed {
      coord4_type x;
      coord4_type y;
   } frame_type;

   typedef struct packed {
      coord4_type lo;
      coord4_type hi;
   } halves_type;

   typedef struct packed {
      coord_type lo;
      coord_type hi;
   } span_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NODE,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_SPLIT,
      ST_POP,
      ST_RIGHT,
      ST_END
   } state_type;

   typedef enum logic [3:0] {
      OP_DXX,
      OP_DYY,
      OP_LIM,
      OP_P1,
      OP_Q1,
      OP_C1,
      OP_P2,
      OP_Q2,
      OP_C2
   } flat_op_type;

   function automatic coord_type mid(input coord_type a, input coord_type b);
      logic signed [COORD_BITS:0] s;
      begin
         s = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
         mid = s[COORD_BITS:1];
      end
   endfunction

   function automatic halves_type split_axis(input coord4_type p);
      coord_type t, l1, r1, l2, r2, c;
      halves_type h;
      begin
         t  = mid(p[1], p[2]);
         l1 = mid(p[0], p[1]);
         r1 = mid(p[2], p[3]);
         l2 = mid(l1, t);
         r2 = mid(t, r1);
         c  = mid(l2, r2);
         h.lo = {c, l2, l1, p[0]};
         h.hi = {p[3], r1, r2, c};
         split_axis = h;
      end
   endfunction

   function automatic span_type box_axis(input coord4_type p);
      span_type s;
      begin
         s.lo = p[0];
         s.hi = p[0];
         for (int k = 1; k < 4; k++) begin
            if ($signed(p[k]) < s.lo) s.lo = p[k];
            if ($signed(p[k]) > s.hi) s.hi = p[k];
         end
         box_axis = s;
      end
   endfunction

   function automatic logic signed [DIFF_BITS-1:0] diff(input coord_type a, input coord_type b);
      diff = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
   endfunction

   function automatic logic [MUL_BITS-1:0] mag(input logic signed [DIFF_BITS-1:0] v);
      logic [DIFF_BITS-1:0] u;
      begin
         u = v[DIFF_BITS-1] ? DIFF_BITS'(-v) : DIFF_BITS'(v);
         mag = MUL_BITS'(u);
      end
   endfunction

endpackage

/* rtl/cbf_mul.sv */
// shared 64x64 multiplier, one 32x32 partial product per cycle
module cbf_mul (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       go,
   input  logic [cbf_pkg::MUL_BITS-1:0]  a,
   input  logic [cbf_pkg::MUL_BITS-1:0]  b,
   output logic                       done,
   output logic [cbf_pkg::PROD_BITS-1:0] prod
);
   import cbf_pkg::*;

   localparam int HALF = MUL_BITS / 2;

   logic [MUL_BITS-1:0]  a_ff, b_ff;
   logic [2:0]           cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic                 ppv_ff, ppv_in;
   logic [1:0]           sh_ff, sh_in;
   logic [MUL_BITS-1:0]  pp_ff, pp_in;
   logic [PROD_BITS-1:0] acc_ff, acc_in;
   logic [HALF-1:0]      limb_a, limb_b;
   logic [PROD_BITS-1:0] pp_shift;

   assign limb_a = cnt_ff[1] ? a_ff[MUL_BITS-1:HALF] : a_ff[HALF-1:0];
   assign limb_b = cnt_ff[0] ? b_ff[MUL_BITS-1:HALF] : b_ff[HALF-1:0];

   always_comb begin
      case (sh_ff)
         2'd0:    pp_shift = PROD_BITS'(pp_ff);
         2'd1:    pp_shift = PROD_BITS'(pp_ff) << HALF;
         2'd2:    pp_shift = PROD_BITS'(pp_ff) << MUL_BITS;
         default: pp_shift = '0;
      endcase
   end

   always_comb begin
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      ppv_in  = 1'b0;
      sh_in   = sh_ff;
      pp_in   = pp_ff;
      acc_in  = acc_ff;
      if (go) begin
         cnt_in = '0;
         run_in = 1'b1;
         acc_in = '0;
      end else if (run_ff) begin
         if (ppv_ff) acc_in = acc_ff + pp_shift;
         if (cnt_ff[2]) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            pp_in  = limb_a * limb_b;
            sh_in  = 2'(cnt_ff[1]) + 2'(cnt_ff[0]);
            ppv_in = 1'b1;
            cnt_in = cnt_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         ppv_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         ppv_ff  <= ppv_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         a_ff <= a;
         b_ff <= b;
      end
      sh_ff  <= sh_in;
      pp_ff  <= pp_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

/* rtl/cbf_stack.sv */
// subdivision stack: control points and clip flag of each level
module cbf_stack #(
   parameter int LEVELS   = 7,
   parameter int LVL_BITS = 3
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic                wr_clip_en,
   input  logic [LVL_BITS-1:0] wr_idx,
   input  cbf_pkg::frame_type  wr_frame,
   input  logic                wr_clip,
   input  logic [LVL_BITS-1:0] rd_idx,
   output cbf_pkg::frame_type  rd_frame,
   output logic                rd_clip
);
   import cbf_pkg::*;

   frame_type frame_ff [LEVELS];
   logic      clip_ff  [LEVELS];

   always_ff @(posedge clock) begin
      if (wr_en) frame_ff[wr_idx] <= wr_frame;
      if (wr_clip_en) clip_ff[wr_idx] <= wr_clip;
   end

   assign rd_frame = frame_ff[rd_idx];
   assign rd_clip  = clip_ff[rd_idx];

endmodule

/* rtl/clipped_bezier_flattener.sv */
// cubic bezier flattener: sequencer, clip test and flatness test on a shared multiplier
//
//   channel  ports                          direction  handshake
//   request  start, busy, req_item          in         start & !busy
//   result   rsp_strobe, rsp_data           out        one-cycle strobe
//   csr      csr_we, csr_idx, csr_wdata     in         write when csr_we
//
// a node at full depth or clipped goes straight to the pop step; any other node
// runs a flatness test of six or nine multiplies, and is split unless it passes;
// the split, the right half, each pop step and the end point are single states.
// reset clears the sequencer and the csr values; the stack needs no clearing.
// results cannot be stalled; busy drops in the cycle that carries the last word.
module clipped_bezier_flattener #(
   parameter int MAX_DEPTH = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  cbf_pkg::req_type                    req_item,
   output logic                                rsp_strobe,
   output cbf_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [cbf_pkg::CSR_IDX_BITS-1:0]    csr_idx,
   input  logic [cbf_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import cbf_pkg::*;

   localparam int LEVELS   = MAX_DEPTH + 1;
   localparam int LVL_BITS = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam logic [LVL_BITS-1:0] LVL_MAX = LVL_BITS'(MAX_DEPTH);

   state_type   state_ff, state_in;
   flat_op_type op_ff, op_in;
   logic [LVL_BITS-1:0] level_ff, level_in, level_up, level_dn;
   logic [1:0]  side_ff [LEVELS];
   logic        need_ff, need_in;
   logic [MUL_BITS-1:0]  sq_ff, sq_in, len_ff, len_in;
   logic [PROD_BITS-1:0] lim_ff, lim_in;
   logic signed [MUL_BITS-1:0] cross_ff, cross_in, sprod;
   logic        rsp_strobe_ff, rsp_strobe_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   coord_type clip_left_ff, clip_top_ff, clip_right_ff, clip_bottom_ff;
   logic [ERR_BITS-1:0] max_err_ff;

   // stack wiring
   logic      st_we, st_clip_we, st_clip_wr;
   logic [LVL_BITS-1:0] st_widx;
   frame_type st_wframe, cur, req_frame;
   logic      cur_clip;
   halves_type hx, hy;

   // multiplier wiring
   logic mul_go, mul_done;
   logic [MUL_BITS-1:0]  mul_a, mul_b;
   logic [PROD_BITS-1:0] mul_prod;
   logic mul_neg, near;

   // geometry
   logic signed [DIFF_BITS-1:0] dx, dy, e1x, e1y, e2x, e2y;
   span_type bx, by;
   coord_type cl, ct, cr, cb;
   logic cut_l, cut_t, cut_r, cut_b, clipped, new_need;

   assign level_up = level_ff + LVL_BITS'(1);
   assign level_dn = level_ff - LVL_BITS'(1);

   assign req_frame.x = {req_item.end_x, req_item.ctrl_b_x, req_item.ctrl_a_x, req_item.start_x};
   assign req_frame.y = {req_item.end_y, req_item.ctrl_b_y, req_item.ctrl_a_y, req_item.start_y};

   cbf_stack #(
      .LEVELS   (LEVELS),
      .LVL_BITS (LVL_BITS)
   ) u_stack (
      .clock      (clock),
      .wr_en      (st_we),
      .wr_clip_en (st_clip_we),
      .wr_idx     (st_widx),
      .wr_frame   (st_wframe),
      .wr_clip    (st_clip_wr),
      .rd_idx     (level_ff),
      .rd_frame   (cur),
      .rd_clip    (cur_clip)
   );

   cbf_mul u_mul (
      .clock (clock),
      .reset (reset),
      .go    (mul_go),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   assign hx = split_axis(cur.x);
   assign hy = split_axis(cur.y);

   // clip test on the control box
   assign bx = box_axis(cur.x);
   assign by = box_axis(cur.y);
   assign cut_l = clip_left_ff > bx.lo;
   assign cut_t = clip_top_ff > by.lo;
   assign cut_r = clip_right_ff < bx.hi;
   assign cut_b = clip_bottom_ff < by.hi;
   assign cl = cut_l ? clip_left_ff : bx.lo;
   assign ct = cut_t ? clip_top_ff : by.lo;
   assign cr = cut_r ? clip_right_ff : bx.hi;
   assign cb = cut_b ? clip_bottom_ff : by.hi;
   assign clipped  = cur_clip && ((cl >= cr) || (ct >= cb));
   assign new_need = cur_clip && (cut_l || cut_t || cut_r || cut_b);

   assign dx  = diff(cur.x[3], cur.x[0]);
   assign dy  = diff(cur.y[3], cur.y[0]);
   assign e1x = diff(cur.x[1], cur.x[0]);
   assign e1y = diff(cur.y[1], cur.y[0]);
   assign e2x = diff(cur.x[2], cur.x[0]);
   assign e2y = diff(cur.y[2], cur.y[0]);

   // multiplier operands for each step of the flatness test
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_neg = 1'b0;
      case (op_ff)
         OP_DXX: begin mul_a = mag(dx); mul_b = mag(dx); end
         OP_DYY: begin mul_a = mag(dy); mul_b = mag(dy); end
         OP_LIM: begin mul_a = MUL_BITS'(max_err_ff); mul_b = len_ff; end
         OP_P1: begin
            mul_a = mag(dx); mul_b = mag(e1y); mul_neg = dx[DIFF_BITS-1] ^ e1y[DIFF_BITS-1];
         end
         OP_Q1: begin
            mul_a = mag(dy); mul_b = mag(e1x); mul_neg = dy[DIFF_BITS-1] ^ e1x[DIFF_BITS-1];
         end
         OP_P2: begin
            mul_a = mag(dx); mul_b = mag(e2y); mul_neg = dx[DIFF_BITS-1] ^ e2y[DIFF_BITS-1];
         end
         OP_Q2: begin
            mul_a = mag(dy); mul_b = mag(e2x); mul_neg = dy[DIFF_BITS-1] ^ e2x[DIFF_BITS-1];
         end
         OP_C1, OP_C2: begin
            mul_a = cross_ff[MUL_BITS-1] ? MUL_BITS'(-cross_ff) : MUL_BITS'(cross_ff);
            mul_b = mul_a;
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign sprod = mul_neg ? -$signed(mul_prod[MUL_BITS-1:0]) : $signed(mul_prod[MUL_BITS-1:0]);
   assign near  = mul_prod < lim_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (start) state_in = ST_NODE;
         ST_NODE:  state_in = (level_ff == LVL_MAX || clipped) ? ST_POP : ST_MUL_GO;
         ST_MUL_GO: state_in = ST_MUL_WAIT;
         ST_MUL_WAIT: begin
            if (mul_done) begin
               case (op_ff)
                  OP_C1:   state_in = near ? ST_MUL_GO : ST_SPLIT;
                  OP_C2:   state_in = near ? ST_POP : ST_SPLIT;
                  default: state_in = ST_MUL_GO;
               endcase
            end
         end
         ST_SPLIT: state_in = ST_NODE;
         ST_POP: begin
            if (level_ff == '0) state_in = ST_END;
            else if (side_ff[level_dn] == SIDE_RIGHT) state_in = ST_RIGHT;
         end
         ST_RIGHT: state_in = ST_NODE;
         ST_END:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      st_we         = 1'b0;
      st_clip_we    = 1'b0;
      st_clip_wr    = 1'b0;
      st_widx       = level_up;
      st_wframe     = req_frame;
      mul_go        = 1'b0;
      op_in         = op_ff;
      level_in      = level_ff;
      need_in       = need_ff;
      sq_in         = sq_ff;
      len_in        = len_ff;
      lim_in        = lim_ff;
      cross_in      = cross_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               st_we      = 1'b1;
               st_clip_we = 1'b1;
               st_clip_wr = 1'b1;
               st_widx    = '0;
               level_in   = '0;
            end
         end
         ST_NODE: begin
            need_in = new_need;
            op_in   = OP_DXX;
         end
         ST_MUL_GO: mul_go = 1'b1;
         ST_MUL_WAIT: begin
            if (mul_done) begin
               case (op_ff)
                  OP_DXX: begin sq_in = mul_prod[MUL_BITS-1:0]; op_in = OP_DYY; end
                  OP_DYY: begin len_in = sq_ff + mul_prod[MUL_BITS-1:0]; op_in = OP_LIM; end
                  OP_LIM: begin lim_in = mul_prod; op_in = OP_P1; end
                  OP_P1:  begin cross_in = sprod; op_in = OP_Q1; end
                  OP_Q1:  begin cross_in = cross_ff - sprod; op_in = OP_C1; end
                  OP_C1:  op_in = OP_P2;
                  OP_P2:  begin cross_in = sprod; op_in = OP_Q2; end
                  OP_Q2:  begin cross_in = cross_ff - sprod; op_in = OP_C2; end
                  OP_C2:  op_in = OP_C2;
                  default: op_in = OP_DXX;
               endcase
            end
         end
         ST_SPLIT: begin
            st_we      = 1'b1;
            st_clip_we = 1'b1;
            st_clip_wr = need_ff;
            st_wframe.x = hx.lo;
            st_wframe.y = hy.lo;
            level_in   = level_up;
         end
         ST_POP: begin
            if (level_ff != '0) level_in = level_dn;
         end
         ST_RIGHT: begin
            st_we       = 1'b1;
            st_wframe.x = hx.hi;
            st_wframe.y = hy.hi;
            level_in    = level_up;
            rsp_strobe_in     = 1'b1;
            rsp_data_in.out_x = hx.lo[3];
            rsp_data_in.out_y = hy.lo[3];
            rsp_data_in.last  = 1'b0;
         end
         ST_END: begin
            rsp_strobe_in     = 1'b1;
            rsp_data_in.out_x = cur.x[3];
            rsp_data_in.out_y = cur.y[3];
            rsp_data_in.last  = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         op_ff          <= OP_DXX;
         level_ff       <= '0;
         rsp_strobe_ff  <= 1'b0;
         clip_left_ff   <= {1'b1, {(COORD_BITS-1){1'b0}}};
         clip_top_ff    <= {1'b1, {(COORD_BITS-1){1'b0}}};
         clip_right_ff  <= {1'b0, {(COORD_BITS-1){1'b1}}};
         clip_bottom_ff <= {1'b0, {(COORD_BITS-1){1'b1}}};
         max_err_ff     <= ERR_BITS'(65536);
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         level_ff      <= level_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_we) begin
            case (csr_idx)
               CSR_CLIP_LEFT:   clip_left_ff   <= csr_wdata[COORD_BITS-1:0];
               CSR_CLIP_TOP:    clip_top_ff    <= csr_wdata[COORD_BITS-1:0];
               CSR_CLIP_RIGHT:  clip_right_ff  <= csr_wdata[COORD_BITS-1:0];
               CSR_CLIP_BOTTOM: clip_bottom_ff <= csr_wdata[COORD_BITS-1:0];
               CSR_MAX_ERR_SQ:  max_err_ff     <= csr_wdata[ERR_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   // side marks: parent goes right-pending on a split, done after its right half
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE:  if (start) side_ff[0] <= SIDE_LEFT;
         ST_SPLIT: begin
            side_ff[level_ff] <= SIDE_RIGHT;
            side_ff[level_up] <= SIDE_LEFT;
         end
         ST_RIGHT: begin
            side_ff[level_ff] <= SIDE_DONE;
            side_ff[level_up] <= SIDE_LEFT;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      need_ff     <= need_in;
      sq_ff       <= sq_in;
      len_ff      <= len_in;
      lim_ff      <= lim_in;
      cross_ff    <= cross_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
